>>> src/lbrf_pkg.sv
// ----------------------------------------------------------------------------
// lbrf_pkg
// Shared constants, command and status codes and word types for the
// length-prefixed byte ring fifo.
// ----------------------------------------------------------------------------
package lbrf_pkg;

  // default sizes
  localparam int unsigned RING_BYTES_DEF   = 1024;
  localparam int unsigned HEADER_BYTES_DEF = 2;
  localparam int unsigned MAX_READ_DEF     = 64;

  // fixed field widths
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIM_W   = 7;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FREE_W  = 11;
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned M_DATA_W = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_BEGIN = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DATA  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEQ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NOSPACE = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_SEQ     = 2'd3;

  // one input word
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [LEN_W-1:0]  elem_len;
    logic [BYTE_W-1:0] data_in;
    logic [LIM_W-1:0]  read_limit;
  } in_item_t;

  // one result word
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] data_out;
    logic              data_valid;
    logic              last;
    logic [FREE_W-1:0] free_bytes;
    logic [LEN_W-1:0]  front_len;
  } result_t;

endpackage

>>> src/lbrf_ring_mem.sv
// ----------------------------------------------------------------------------
// lbrf_ring_mem
// Byte ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lbrf_ring_mem #(
  parameter int unsigned DEPTH = lbrf_pkg::RING_BYTES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [lbrf_pkg::BYTE_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [lbrf_pkg::BYTE_W-1:0] rdata_o
);

  logic [lbrf_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [lbrf_pkg::BYTE_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/lbrf_out_reg.sv
// ----------------------------------------------------------------------------
// lbrf_out_reg
// Output register for result words; decouples the sequencer from the
// downstream ready.
// ----------------------------------------------------------------------------
module lbrf_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  lbrf_pkg::result_t res_i,
  output logic              can_load_o,
  output logic              valid_o,
  input  logic              ready_i,
  output lbrf_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  lbrf_pkg::result_t res_q;

  assign can_load_o = !valid_q || ready_i;

  // valid flag
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> src/lbrf_ctrl.sv
// ----------------------------------------------------------------------------
// lbrf_ctrl
// Command sequencer: keeps the ring pointers, space count and front length,
// writes headers and data bytes, and walks the ring for dequeue and peek.
// ----------------------------------------------------------------------------
module lbrf_ctrl #(
  parameter int unsigned RING_BYTES   = lbrf_pkg::RING_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = lbrf_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_READ     = lbrf_pkg::MAX_READ_DEF,
  parameter int unsigned AW           = $clog2(RING_BYTES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input side
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  lbrf_pkg::in_item_t          item_i,
  // result side
  input  logic                        can_load_i,
  output logic                        load_o,
  output lbrf_pkg::result_t           res_o,
  // ring memory
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [lbrf_pkg::BYTE_W-1:0] mem_wdata_o,
  output logic                        mem_re_o,
  output logic [AW-1:0]               mem_raddr_o,
  input  logic [lbrf_pkg::BYTE_W-1:0] mem_rdata_i
);

  localparam int unsigned LEN_W = lbrf_pkg::LEN_W;
  localparam int unsigned LIM_W = lbrf_pkg::LIM_W;
  localparam int unsigned SPW   = $clog2(RING_BYTES + 1);
  localparam int unsigned HW    = 8 * HEADER_BYTES;
  localparam int unsigned HCW   = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int unsigned SUMW  = ((SPW > LEN_W) ? SPW : LEN_W) + 2;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_WR_HDR = 7'b0000010,
    ST_HDR_RD = 7'b0000100,
    ST_HDR_CP = 7'b0001000,
    ST_DAT_RD = 7'b0010000,
    ST_DAT_OT = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_e;

  state_e                      state_q, state_d;
  logic [AW-1:0]               rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]               wr_ptr_q, wr_ptr_d;
  logic [SPW-1:0]              space_q, space_d;
  logic [LEN_W-1:0]            pend_q, pend_d;
  logic [LEN_W-1:0]            front_q, front_d;
  logic [LEN_W-1:0]            len_q, len_d;
  logic [HCW-1:0]              hcnt_q, hcnt_d;
  logic [HW-1:0]               hacc_q, hacc_d;
  logic [AW-1:0]               hptr_q, hptr_d;
  logic [AW-1:0]               daddr_q, daddr_d;
  logic [LIM_W-1:0]            n_q, n_d;
  logic [LIM_W-1:0]            cnt_q, cnt_d;
  logic [lbrf_pkg::STAT_W-1:0] status_q, status_d;

  logic                        accept;
  logic                        empty;
  logic [SUMW-1:0]             need;
  logic [HW+LEN_W-1:0]         len_wide;
  logic                        too_big;
  logic                        fit_fail;
  logic [LIM_W-1:0]            lim_sat;
  logic [LIM_W-1:0]            n_calc;
  logic [AW-1:0]               rp_data;
  logic [AW-1:0]               rp_next;
  logic [SUMW-1:0]             space_rel;
  logic [SPW-1:0]              space_sat;
  logic [HW+LEN_W-1:0]         hdr_wide;
  logic [HW+LEN_W-1:0]         hacc_wide;
  logic                        hcnt_last;

  // pointer step with wrap
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(RING_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  // reduce a sum known to stay below twice the ring size
  function automatic logic [AW-1:0] ring_wrap(input logic [SUMW-1:0] s);
    return (s >= SUMW'(RING_BYTES)) ? AW'(s - SUMW'(RING_BYTES)) : AW'(s);
  endfunction

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign empty      = (space_q == SPW'(RING_BYTES));

  // enqueue admission
  assign need     = SUMW'(item_i.elem_len) + SUMW'(HEADER_BYTES);
  assign len_wide = {{HW{1'b0}}, item_i.elem_len};
  assign too_big  = |(len_wide >> HW);
  assign fit_fail = (need > SUMW'(space_q)) || too_big;

  // read length for dequeue and peek
  assign lim_sat = (item_i.read_limit > LIM_W'(MAX_READ)) ? LIM_W'(MAX_READ)
                                                          : item_i.read_limit;
  assign n_calc  = (front_q < LEN_W'(lim_sat)) ? LIM_W'(front_q) : lim_sat;

  // addresses and space after a dequeue
  assign rp_data   = ring_wrap(SUMW'(rd_ptr_q) + SUMW'(HEADER_BYTES));
  assign rp_next   = ring_wrap(SUMW'(rp_data) + SUMW'(front_q));
  assign space_rel = SUMW'(space_q) + SUMW'(front_q) + SUMW'(HEADER_BYTES);
  assign space_sat = (space_rel > SUMW'(RING_BYTES)) ? SPW'(RING_BYTES)
                                                     : SPW'(space_rel);

  // header bytes, little endian
  assign hdr_wide  = {{HW{1'b0}}, len_q};
  assign hcnt_last = (hcnt_q == HCW'(HEADER_BYTES - 1));

  always_comb begin
    hacc_d = hacc_q;
    if (state_q == ST_HDR_CP) begin
      hacc_d[hcnt_q*8 +: 8] = mem_rdata_i;
    end
  end

  assign hacc_wide = {{LEN_W{1'b0}}, hacc_d};

  // sequencer
  always_comb begin
    state_d     = state_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    space_d     = space_q;
    pend_d      = pend_q;
    front_d     = front_q;
    len_d       = len_q;
    hcnt_d      = hcnt_q;
    hptr_d      = hptr_q;
    daddr_d     = daddr_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_wdata_o = item_i.data_in;
    mem_re_o    = 1'b0;
    mem_raddr_o = daddr_q;
    load_o      = 1'b0;
    res_o.status     = status_q;
    res_o.data_out   = '0;
    res_o.data_valid = 1'b0;
    res_o.last       = 1'b1;
    res_o.free_bytes = lbrf_pkg::FREE_W'(space_q);
    res_o.front_len  = front_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          status_d = lbrf_pkg::STATUS_OK;
          state_d  = ST_RESP;
          unique case (item_i.cmd)
            lbrf_pkg::CMD_BEGIN: begin
              if (pend_q != '0) begin
                status_d = lbrf_pkg::STATUS_SEQ;
              end else if (fit_fail) begin
                status_d = lbrf_pkg::STATUS_NOSPACE;
              end else begin
                space_d = SPW'(SUMW'(space_q) - need);
                pend_d  = item_i.elem_len;
                len_d   = item_i.elem_len;
                hcnt_d  = '0;
                if (empty) begin
                  front_d = item_i.elem_len;
                end
                state_d = ST_WR_HDR;
              end
            end
            lbrf_pkg::CMD_DATA: begin
              if (pend_q == '0) begin
                status_d = lbrf_pkg::STATUS_SEQ;
              end else begin
                mem_we_o = 1'b1;
                wr_ptr_d = ptr_inc(wr_ptr_q);
                pend_d   = pend_q - 1'b1;
              end
            end
            lbrf_pkg::CMD_DEQ, lbrf_pkg::CMD_PEEK: begin
              if (pend_q != '0) begin
                status_d = lbrf_pkg::STATUS_SEQ;
              end else if (empty) begin
                status_d = lbrf_pkg::STATUS_EMPTY;
              end else begin
                n_d     = n_calc;
                cnt_d   = '0;
                daddr_d = rp_data;
                if (n_calc != '0) begin
                  state_d = ST_DAT_RD;
                end
                if (item_i.cmd == lbrf_pkg::CMD_DEQ) begin
                  rd_ptr_d = rp_next;
                  space_d  = space_sat;
                  if (space_sat == SPW'(RING_BYTES)) begin
                    front_d = '0;
                  end else begin
                    // fetch the next front header first
                    hptr_d  = rp_next;
                    hcnt_d  = '0;
                    state_d = ST_HDR_RD;
                  end
                end
              end
            end
            lbrf_pkg::CMD_CLEAR: begin
              rd_ptr_d = '0;
              wr_ptr_d = '0;
              space_d  = SPW'(RING_BYTES);
              pend_d   = '0;
              front_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WR_HDR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = hdr_wide[hcnt_q*8 +: 8];
        wr_ptr_d    = ptr_inc(wr_ptr_q);
        if (hcnt_last) begin
          hcnt_d  = '0;
          state_d = ST_RESP;
        end else begin
          hcnt_d = hcnt_q + 1'b1;
        end
      end
      ST_HDR_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = hptr_q;
        hptr_d      = ptr_inc(hptr_q);
        state_d     = ST_HDR_CP;
      end
      ST_HDR_CP: begin
        if (hcnt_last) begin
          hcnt_d  = '0;
          front_d = hacc_wide[LEN_W-1:0];
          state_d = (n_q == '0) ? ST_RESP : ST_DAT_RD;
        end else begin
          hcnt_d  = hcnt_q + 1'b1;
          state_d = ST_HDR_RD;
        end
      end
      ST_DAT_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = daddr_q;
        daddr_d     = ptr_inc(daddr_q);
        state_d     = ST_DAT_OT;
      end
      ST_DAT_OT: begin
        res_o.data_out   = mem_rdata_i;
        res_o.data_valid = 1'b1;
        res_o.last       = (cnt_q == n_q - 1'b1);
        if (can_load_i) begin
          load_o  = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = (cnt_q == n_q - 1'b1) ? ST_IDLE : ST_DAT_RD;
        end
      end
      ST_RESP: begin
        if (can_load_i) begin
          load_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign mem_waddr_o = wr_ptr_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      space_q  <= SPW'(RING_BYTES);
      pend_q   <= '0;
      front_q  <= '0;
      hcnt_q   <= '0;
      n_q      <= '0;
      cnt_q    <= '0;
      status_q <= lbrf_pkg::STATUS_OK;
    end else begin
      state_q  <= state_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      space_q  <= space_d;
      pend_q   <= pend_d;
      front_q  <= front_d;
      hcnt_q   <= hcnt_d;
      n_q      <= n_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    hacc_q  <= hacc_d;
    hptr_q  <= hptr_d;
    daddr_q <= daddr_d;
  end

endmodule

>>> src/length_prefixed_byte_ring_fifo.sv
// Sequence: begin enqueue writes the header bytes (ST_WR_HDR) before its result word;
//   dequeue/peek read each byte on the single ring read port (ST_DAT_RD, then ST_DAT_OT),
//   and a dequeue first fetches the next front header (ST_HDR_RD, ST_HDR_CP).
// Flow: one item in flight at a time; no new item is taken until the last is through.
// Reset: pointers, counts and output valid clear at once; ring not cleared.
// ----------------------------------------------------------------------------
// length_prefixed_byte_ring_fifo
// FIFO of variable-length elements kept as length header plus bytes in a
// byte ring, with enqueue, byte push, dequeue, peek and clear commands.
// ----------------------------------------------------------------------------
module length_prefixed_byte_ring_fifo #(
  parameter int unsigned RING_BYTES   = lbrf_pkg::RING_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = lbrf_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_READ     = lbrf_pkg::MAX_READ_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input words
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // elem_len[9:0], data_in[17:10], read_limit[24:18], zero[31:25]
  input  logic [lbrf_pkg::S_DATA_W-1:0] s_axis_tdata_i,
  // cmd[2:0]
  input  logic [lbrf_pkg::CMD_W-1:0]    s_axis_tuser_i,
  // result words
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // status[1:0], data_out[9:2], free_bytes[20:10], front_len[30:21], zero[31]
  output logic [lbrf_pkg::M_DATA_W-1:0] m_axis_tdata_o,
  output logic                          m_axis_tlast_o,
  // data_valid[0]
  output logic                          m_axis_tuser_o
);

  localparam int unsigned AW = $clog2(RING_BYTES);

  lbrf_pkg::in_item_t          item;
  lbrf_pkg::result_t           res_new;
  lbrf_pkg::result_t           res_out;
  logic                        load;
  logic                        can_load;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [lbrf_pkg::BYTE_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [lbrf_pkg::BYTE_W-1:0] mem_rdata;

  // unpack input word
  assign item.cmd        = s_axis_tuser_i;
  assign item.elem_len   = s_axis_tdata_i[9:0];
  assign item.data_in    = s_axis_tdata_i[17:10];
  assign item.read_limit = s_axis_tdata_i[24:18];

  lbrf_ctrl #(
    .RING_BYTES  (RING_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_READ    (MAX_READ),
    .AW          (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .item_i     (item),
    .can_load_i (can_load),
    .load_o     (load),
    .res_o      (res_new),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  lbrf_ring_mem #(
    .DEPTH(RING_BYTES),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  lbrf_out_reg u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .res_i     (res_new),
    .can_load_o(can_load),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .res_o     (res_out)
  );

  // pack result word
  assign m_axis_tdata_o = {1'b0, res_out.front_len, res_out.free_bytes,
                           res_out.data_out, res_out.status};
  assign m_axis_tlast_o = res_out.last;
  assign m_axis_tuser_o = res_out.data_valid;

endmodule

>>> src/lbrf_checker.sv
// ----------------------------------------------------------------------------
// lbrf_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module lbrf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_i,
  input logic                          m_axis_tready_i,
  input logic [lbrf_pkg::M_DATA_W-1:0] m_axis_tdata_i,
  input logic                          m_axis_tlast_i,
  input logic                          m_axis_tuser_i
);

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tlast_i) &&
      $stable(m_axis_tuser_i))
    else $error("result word changed while stalled");

  // a word without data is the only word of its command
  a_nodata_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tuser_i |-> m_axis_tlast_i)
    else $error("status word not marked last");

  // a word without data carries a zero byte
  a_nodata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tuser_i |-> m_axis_tdata_i[9:2] == '0)
    else $error("status word carries a data byte");

  // error status never comes with data
  a_err_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (m_axis_tdata_i[1:0] != lbrf_pkg::STATUS_OK) |->
      !m_axis_tuser_i)
    else $error("data byte returned with error status");

endmodule

bind length_prefixed_byte_ring_fifo lbrf_checker u_lbrf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_i(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_i (m_axis_tdata_o),
  .m_axis_tlast_i (m_axis_tlast_o),
  .m_axis_tuser_i (m_axis_tuser_o)
);
